[sv/dgt_pkg.sv]
package dgt_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int DAYS_W   = 22;
	localparam int TOTAL_W  = 24;
	localparam int OUT_CNT_W = 16;

	localparam logic [YEAR_W-1:0] EPOCH_RESET = 14'd2010;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_INVALID  = 2'd1,
		ST_EARLIER  = 2'd2
	} status_t;

	// floor(x / 100) for x below 2^15 by reciprocal multiply
	function automatic logic [8:0] div100(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'd5243;
		return p[27:19];
	endfunction

	// number of leap years in [0, y)
	function automatic logic [11:0] leaps_before(input logic [YEAR_W-1:0] y);
		logic [11:0] q4;
		logic [8:0]  q100;
		logic [8:0]  q400;
		logic [14:0] a;
		q4   = 12'((15'(y) + 15'd3) >> 2);
		q100 = div100(15'(y) + 15'd99);
		a    = 15'(y) + 15'd399;
		q400 = div100(a >> 2);
		return q4 - 12'(q100) + 12'(q400);
	endfunction

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [8:0]        q;
		logic [YEAR_W-1:0] r;
		q = div100(15'(y));
		r = y - YEAR_W'(YEAR_W'(q) * YEAR_W'(100));
		return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
	endfunction

	// days in all years before y, counted from year 0
	function automatic logic [TOTAL_W-1:0] year_days(input logic [YEAR_W-1:0] y);
		return TOTAL_W'(TOTAL_W'(y) * TOTAL_W'(365)) + TOTAL_W'(leaps_before(y));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] d;
		case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

[sv/date_gap_tracker_core.sv]
// Date gap tracker: takes one year/month/day date per input beat, checks it
// against the Gregorian calendar (leap years, month lengths, epoch_year up to
// MAX_YEAR) and turns a valid date into a day number where January first of
// the epoch year is day 1. A date earlier than the last accepted one is
// rejected; an equal date is accepted with a gap of zero. Each input beat
// yields exactly one output beat carrying the status, the day number, the gap
// to the previous accepted date and the running statistics (saturating
// valid/invalid counts, shortest, longest and total gap). The block takes one
// date per clock cycle while the output is not stalled by m_tready; a date passes
// through an input register, a day-number stage (one constant multiply and the
// divide-by-100 reciprocals) and a single compare-update against the stored
// previous date, which feeds the output register. The epoch register is
// written through cfg_wr_en/cfg_wr_data, by the user only while the block is
// idle (not enforced by the block); its day offset is formed at the write.
module date_gap_tracker_core
	import dgt_pkg::*;
#(
	parameter int MAX_YEAR    = 9999,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [YEAR_W-1:0]   cfg_wr_data,  // epoch_year
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [23:0]         s_tdata,      // year[13:0], month[17:14], day[22:18], zero[23]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [143:0]        m_tdata,      // day_number[21:0], gap_days[43:22],
	                                          // valid_total[59:44], invalid_total[75:60],
	                                          // shortest_gap[97:76], longest_gap[119:98],
	                                          // gap_sum[141:120], zero[143:142]
	output logic [2:0]          m_tuser       // status[1:0], gap_valid[2]
);

	localparam logic [YEAR_W-1:0]  MAX_YEAR_C       = YEAR_W'(MAX_YEAR);
	localparam logic [TOTAL_W-1:0] EPOCH_DAYS_RESET = year_days(EPOCH_RESET);

	// epoch register and its precomputed day offset
	logic [YEAR_W-1:0]  epoch_q;
	logic [TOTAL_W-1:0] epoch_days_q;

	// input stage
	logic               v_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;

	// day-number stage
	logic               v_s2;
	logic               ok_s2;
	logic [DAYS_W-1:0]  dn_s2;

	// output register
	logic               m_tvalid_q;
	status_t            status_q;
	logic [DAYS_W-1:0]  dn_q;
	logic [DAYS_W-1:0]  gap_q;
	logic               gv_q;

	// tracker state
	logic [DAYS_W-1:0]      prev_q;
	logic [COUNT_WIDTH-1:0] acc_q;
	logic [COUNT_WIDTH-1:0] rej_q;
	logic [DAYS_W-1:0]      min_q;
	logic [DAYS_W-1:0]      max_q;
	logic [DAYS_W-1:0]      sum_q;

	// flow control: each stage advances when the one after it can take a beat
	logic ready_out;
	logic ready_s2;
	logic adv_b;

	assign ready_out = !m_tvalid_q || m_tready;
	assign ready_s2  = !v_s2 || ready_out;
	assign s_tready  = !v_s1 || ready_s2;
	assign adv_b     = v_s2 && ready_out;

	// ---------------------------------------------------------------------
	// Stage A: validate the date and form its day number
	// ---------------------------------------------------------------------
	logic              leap_a;
	logic [DAY_W-1:0]  len_a;
	logic              ok_a;
	logic [9:0]        doy_a;
	logic [DAYS_W-1:0] dn_a;

	always_comb begin
		leap_a = is_leap(year_s1);
		len_a  = month_len(month_s1, leap_a);
		ok_a   = (year_s1 >= epoch_q) && (year_s1 <= MAX_YEAR_C) &&
		         (month_s1 >= 4'd1) && (month_s1 <= 4'd12) &&
		         (day_s1 >= 5'd1) && (day_s1 <= len_a);
		// day of year, with February 29 counted once past February
		doy_a  = 10'(days_before(month_s1)) + 10'(leap_a && (month_s1 > 4'd2)) + 10'(day_s1);
		// difference of absolute day counts; fits 22 bits for any valid date
		dn_a   = DAYS_W'(year_days(year_s1) + TOTAL_W'(doy_a) - epoch_days_q);
	end

	// ---------------------------------------------------------------------
	// Stage B: compare against the previous date and update statistics
	// ---------------------------------------------------------------------
	status_t                status_b;
	logic [DAYS_W-1:0]      dn_b;
	logic [DAYS_W-1:0]      gap_b;
	logic                   gv_b;
	logic [DAYS_W-1:0]      gap_raw;
	logic [DAYS_W:0]        sum_wide;
	logic                   first_gap;
	logic [COUNT_WIDTH-1:0] acc_inc;
	logic [COUNT_WIDTH-1:0] rej_inc;
	logic [DAYS_W-1:0]      prev_n;
	logic [COUNT_WIDTH-1:0] acc_n;
	logic [COUNT_WIDTH-1:0] rej_n;
	logic [DAYS_W-1:0]      min_n;
	logic [DAYS_W-1:0]      max_n;
	logic [DAYS_W-1:0]      sum_n;

	assign gap_raw   = dn_s2 - prev_q;
	assign sum_wide  = {1'b0, sum_q} + {1'b0, gap_raw};
	assign first_gap = (acc_q == COUNT_WIDTH'(1));
	// saturating increments: hold at all ones
	assign acc_inc   = (acc_q == '1) ? acc_q : acc_q + COUNT_WIDTH'(1);
	assign rej_inc   = (rej_q == '1) ? rej_q : rej_q + COUNT_WIDTH'(1);

	always_comb begin
		status_b = ST_INVALID;
		dn_b     = '0;
		gap_b    = '0;
		gv_b     = 1'b0;
		prev_n   = prev_q;
		acc_n    = acc_q;
		rej_n    = rej_q;
		min_n    = min_q;
		max_n    = max_q;
		sum_n    = sum_q;
		if (!ok_s2) begin
			rej_n = rej_inc;
		end else if (dn_s2 < prev_q) begin
			status_b = ST_EARLIER;
			rej_n    = rej_inc;
		end else begin
			status_b = ST_ACCEPTED;
			dn_b     = dn_s2;
			acc_n    = acc_inc;
			prev_n   = dn_s2;
			// a gap exists from the second accepted date on
			if (acc_q != '0) begin
				gap_b = gap_raw;
				gv_b  = 1'b1;
				sum_n = sum_wide[DAYS_W] ? '1 : sum_wide[DAYS_W-1:0];
				if (first_gap || (gap_raw > max_q)) begin
					max_n = gap_raw;
				end
				if (first_gap || (gap_raw < min_q)) begin
					min_n = gap_raw;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= EPOCH_RESET;
			epoch_days_q <= EPOCH_DAYS_RESET;
		end else if (cfg_wr_en) begin
			epoch_q      <= cfg_wr_data;
			epoch_days_q <= year_days(cfg_wr_data);
		end
	end

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_out) begin
				m_tvalid_q <= v_s2;
			end
		end
	end

	// payload: load only on advance, hold otherwise
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			year_s1  <= s_tdata[13:0];
			month_s1 <= s_tdata[17:14];
			day_s1   <= s_tdata[22:18];
		end
		if (v_s1 && ready_s2) begin
			ok_s2 <= ok_a;
			dn_s2 <= dn_a;
		end
		if (adv_b) begin
			status_q <= status_b;
			dn_q     <= dn_b;
			gap_q    <= gap_b;
			gv_q     <= gv_b;
		end
	end

	// tracker state advances together with the output register, so it
	// stays stable while a result waits and reads out as the "after" values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			acc_q  <= '0;
			rej_q  <= '0;
			min_q  <= '0;
			max_q  <= '0;
			sum_q  <= '0;
		end else if (adv_b) begin
			prev_q <= prev_n;
			acc_q  <= acc_n;
			rej_q  <= rej_n;
			min_q  <= min_n;
			max_q  <= max_n;
			sum_q  <= sum_n;
		end
	end

	// ---------------------------------------------------------------------
	// Outputs
	// ---------------------------------------------------------------------
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {gv_q, status_q};
	assign m_tdata  = {2'b00, sum_q, max_q, min_q,
	                   OUT_CNT_W'(rej_q), OUT_CNT_W'(acc_q), gap_q, dn_q};

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= max_q)
		else $error("shortest gap exceeds longest gap");

	a_gap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && gv_q) |-> ((gap_q >= min_q) && (gap_q <= max_q)))
		else $error("reported gap outside shortest/longest range");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && (status_q != ST_ACCEPTED)) |-> ((dn_q == '0) && !gv_q && (gap_q == '0)))
		else $error("rejected date carries day number or gap");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid_q |-> s_tready)
		else $error("input stalled with empty output register");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import dgt_pkg::*;

	localparam int          MAX_YEAR   = 9999;
	localparam int unsigned COUNT_MAX  = 32'h0000_FFFF;
	localparam int unsigned DAYS_MAX   = 32'h003F_FFFF;
	localparam int unsigned MONTH_START [16] =
		'{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 0, 0, 0};

	typedef struct packed {
		status_t     status;
		logic [21:0] day_number;
		logic [21:0] gap_days;
		logic        gap_valid;
		logic [15:0] valid_total;
		logic [15:0] invalid_total;
		logic [21:0] shortest_gap;
		logic [21:0] longest_gap;
		logic [21:0] gap_sum;
	} date_result_t;

	// one directed date; typed rows carry status and day number read off by hand
	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        typed;
		status_t     status;
		logic [21:0] day_number;
	} date_row_t;

	localparam int DIR_ROWS = 24;
	date_row_t date_rows [DIR_ROWS] = '{
		'{14'd2010,  4'd1,  5'd1,  1'b1, ST_ACCEPTED, 22'd1},    // epoch start, first date
		'{14'd2010,  4'd1,  5'd1,  1'b1, ST_ACCEPTED, 22'd1},    // equal date, zero gap
		'{14'd2010,  4'd12, 5'd31, 1'b1, ST_ACCEPTED, 22'd365},
		'{14'd2012,  4'd2,  5'd29, 1'b1, ST_ACCEPTED, 22'd790},  // leap day
		'{14'd2012,  4'd3,  5'd1,  1'b0, ST_ACCEPTED, 22'd0},
		'{14'd2009,  4'd12, 5'd31, 1'b1, ST_INVALID,  22'd0},    // before epoch
		'{14'd2011,  4'd6,  5'd1,  1'b1, ST_EARLIER,  22'd0},
		'{14'd2013,  4'd0,  5'd5,  1'b1, ST_INVALID,  22'd0},
		'{14'd2013,  4'd13, 5'd1,  1'b1, ST_INVALID,  22'd0},
		'{14'd2013,  4'd15, 5'd31, 1'b1, ST_INVALID,  22'd0},
		'{14'd2013,  4'd4,  5'd31, 1'b1, ST_INVALID,  22'd0},
		'{14'd2013,  4'd1,  5'd0,  1'b1, ST_INVALID,  22'd0},
		'{14'd2013,  4'd2,  5'd29, 1'b1, ST_INVALID,  22'd0},    // common year
		'{14'd2100,  4'd2,  5'd29, 1'b1, ST_INVALID,  22'd0},    // century, not leap
		'{14'd10000, 4'd1,  5'd1,  1'b1, ST_INVALID,  22'd0},    // beyond max year
		'{14'd16383, 4'd15, 5'd31, 1'b1, ST_INVALID,  22'd0},    // all ones
		'{14'd9999,  4'd2,  5'd29, 1'b1, ST_INVALID,  22'd0},
		'{14'd0,     4'd0,  5'd0,  1'b1, ST_INVALID,  22'd0},    // all zeros
		'{14'd2100,  4'd3,  5'd1,  1'b0, ST_ACCEPTED, 22'd0},
		'{14'd2400,  4'd2,  5'd29, 1'b0, ST_ACCEPTED, 22'd0},    // 400-year leap day
		'{14'd2400,  4'd12, 5'd31, 1'b0, ST_ACCEPTED, 22'd0},
		'{14'd2399,  4'd1,  5'd1,  1'b1, ST_EARLIER,  22'd0},
		'{14'd2400,  4'd12, 5'd31, 1'b0, ST_ACCEPTED, 22'd0},
		'{14'd2400,  4'd12, 5'd30, 1'b1, ST_EARLIER,  22'd0}
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [13:0]  cfg_wr_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [23:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic [2:0]   m_tuser;

	// handshake hints to the result side, driven at edges
	logic hold_start = 1'b0;
	logic calm = 1'b0;

	date_result_t pending_results [$];
	int           mismatches = 0;

	// predictor state
	int unsigned epoch_cfg = 32'(EPOCH_RESET);
	int unsigned last_day_number = 0;
	int unsigned accepted_cnt = 0;
	int unsigned rejected_cnt = 0;
	int unsigned shortest = 0;
	int unsigned longest = 0;
	int unsigned gap_total = 0;

	// date cursor for well-formed runs
	int unsigned cur_y = 2400;
	int unsigned cur_m = 12;
	int unsigned cur_d = 31;

	date_gap_tracker_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit leap_year(input int unsigned y);
		return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
	endfunction

	// leap years in [0, y), year 0 included
	function automatic int unsigned leaps_up_to(input int unsigned y);
		if (y == 0)
			return 0;
		return (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic int unsigned sat_count(input int unsigned c);
		return (c < COUNT_MAX) ? c + 1 : COUNT_MAX;
	endfunction

	// classify one date, advance the statistics, return the result beat
	function automatic date_result_t track_date(input logic [13:0] year, input logic [3:0] month,
			input logic [4:0] day);
		date_result_t r;
		int unsigned  y;
		int unsigned  m;
		int unsigned  d;
		int unsigned  dn;
		int unsigned  g;
		bit           ok;
		r  = '0;
		y  = 32'(year);
		m  = 32'(month);
		d  = 32'(day);
		ok = (y >= epoch_cfg) && (y <= MAX_YEAR) && (m >= 1) && (m <= 12) && (d >= 1);
		if (ok && d > month_days(y, m))
			ok = 1'b0;
		if (!ok) begin
			r.status     = ST_INVALID;
			rejected_cnt = sat_count(rejected_cnt);
		end else begin
			dn = 365 * (y - epoch_cfg) + (leaps_up_to(y) - leaps_up_to(epoch_cfg))
				+ MONTH_START[month] + ((leap_year(y) && m > 2) ? 1 : 0) + d;
			dn = dn & DAYS_MAX;
			if (dn < last_day_number) begin
				r.status     = ST_EARLIER;
				rejected_cnt = sat_count(rejected_cnt);
			end else begin
				r.day_number = 22'(dn);
				if (accepted_cnt >= 1) begin
					g           = dn - last_day_number;
					r.gap_days  = 22'(g);
					r.gap_valid = 1'b1;
					gap_total   = (gap_total + g > DAYS_MAX) ? DAYS_MAX : gap_total + g;
					if (accepted_cnt == 1 || g > longest)
						longest = g;
					if (accepted_cnt == 1 || g < shortest)
						shortest = g;
				end
				accepted_cnt    = sat_count(accepted_cnt);
				last_day_number = dn;
			end
		end
		r.valid_total   = 16'(accepted_cnt);
		r.invalid_total = 16'(rejected_cnt);
		r.shortest_gap  = 22'(shortest);
		r.longest_gap   = 22'(longest);
		r.gap_sum       = 22'(gap_total);
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch %s at %0t: got %0d expected %0d", what, $realtime, got, want);
		mismatches++;
	endtask

	task automatic check_result();
		date_result_t want;
		if (pending_results.size() == 0) begin
			flag_mismatch("result beat with no pending date", 1, 0);
		end else begin
			want = pending_results.pop_front();
			if (m_tuser[1:0] !== want.status)
				flag_mismatch("status", 32'(m_tuser[1:0]), 32'(want.status));
			if (m_tuser[2] !== want.gap_valid)
				flag_mismatch("gap_valid", 32'(m_tuser[2]), 32'(want.gap_valid));
			if (m_tdata[21:0] !== want.day_number)
				flag_mismatch("day_number", 32'(m_tdata[21:0]), 32'(want.day_number));
			if (m_tdata[43:22] !== want.gap_days)
				flag_mismatch("gap_days", 32'(m_tdata[43:22]), 32'(want.gap_days));
			if (m_tdata[59:44] !== want.valid_total)
				flag_mismatch("valid_total", 32'(m_tdata[59:44]), 32'(want.valid_total));
			if (m_tdata[75:60] !== want.invalid_total)
				flag_mismatch("invalid_total", 32'(m_tdata[75:60]),
					32'(want.invalid_total));
			if (m_tdata[97:76] !== want.shortest_gap)
				flag_mismatch("shortest_gap", 32'(m_tdata[97:76]), 32'(want.shortest_gap));
			if (m_tdata[119:98] !== want.longest_gap)
				flag_mismatch("longest_gap", 32'(m_tdata[119:98]), 32'(want.longest_gap));
			if (m_tdata[141:120] !== want.gap_sum)
				flag_mismatch("gap_sum", 32'(m_tdata[141:120]), 32'(want.gap_sum));
		end
	endtask

	// offer one date beat, hold it until accepted, then queue its prediction
	task automatic offer_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
			input bit typed, input status_t t_status, input logic [21:0] t_dn);
		date_result_t r;
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, d, m, y};
		do
			@(posedge clk);
		while (!s_tready);
		r = track_date(y, m, d);
		if (typed) begin
			r.status     = t_status;
			r.day_number = t_dn;
		end
		pending_results.push_back(r);
	endtask

	task automatic pause_sender(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// drop valid and wait until every pending result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_epoch(input logic [13:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		epoch_cfg = 32'(v);
		@(posedge clk);
	endtask

	task automatic advance_cursor(input int n);
		repeat (n) begin
			if (cur_y == MAX_YEAR && cur_m == 12 && cur_d == 31)
				return;
			cur_d++;
			if (cur_d > month_days(cur_y, cur_m)) begin
				cur_d = 1;
				cur_m++;
				if (cur_m > 12) begin
					cur_m = 1;
					cur_y++;
				end
			end
		end
	endtask

	// mostly well-formed, increasing dates; the rest noise and broken dates
	task automatic next_random_date(output logic [13:0] y, output logic [3:0] m,
			output logic [4:0] d);
		int unsigned pick;
		int unsigned len;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			advance_cursor($urandom_range(0, 45));
			y = 14'(cur_y); m = 4'(cur_m); d = 5'(cur_d);
		end else if (pick < 75) begin
			cur_y = cur_y + $urandom_range(1, 25);
			if (cur_y > MAX_YEAR)
				cur_y = MAX_YEAR;
			if (cur_d > month_days(cur_y, cur_m))
				cur_d = month_days(cur_y, cur_m);
			y = 14'(cur_y); m = 4'(cur_m); d = 5'(cur_d);
		end else if (pick < 83) begin
			y = 14'($urandom_range(0, 16383));
			m = 4'($urandom_range(0, 15));
			d = 5'($urandom_range(0, 31));
		end else if (pick < 90) begin
			y = (cur_y > 60) ? 14'(cur_y - $urandom_range(1, 60)) : 14'd0;
			m = 4'($urandom_range(1, 12));
			d = 5'($urandom_range(1, 28));
		end else begin
			y = 14'(cur_y);
			m = 4'($urandom_range(1, 12));
			d = 5'($urandom_range(1, 28));
			case ($urandom_range(0, 3))
				0: m = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
				1: begin
					len = month_days(cur_y, 32'(m));
					d   = (len == 31) ? 5'd0 : 5'($urandom_range(len + 1, 31));
				end
				2: y = 14'($urandom_range(MAX_YEAR + 1, 16383));
				default: d = 5'd0;
			endcase
		end
	endtask

	// one random phase; from calm_from on, the sender never idles
	task automatic run_phase(input int count, input int calm_from);
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		bit          quiet;
		for (int i = 0; i < count; i++) begin
			quiet = (calm_from >= 0) && (i >= calm_from);
			if (quiet && i == calm_from)
				calm <= 1'b1;
			if (!quiet && (i / 64) % 3 != 0 && $urandom_range(0, 99) < 15)
				pause_sender($urandom_range(1, 14));
			next_random_date(y, m, d);
			offer_date(y, m, d, 1'b0, ST_ACCEPTED, '0);
		end
	endtask

	// result side: check every beat, stall in bursts, take the one long hold
	initial begin : result_side
		int idle_left;
		int hold_left;
		int rcycle;
		bit hold_taken;
		idle_left  = 0;
		hold_left  = 0;
		rcycle     = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			rcycle++;
			if (arst_n && m_tvalid && m_tready)
				check_result();
			if (hold_start && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = 300;
			end
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				m_tready <= 1'b0;
			end else if (!calm && (rcycle / 200) % 3 != 0 && $urandom_range(0, 99) < 12) begin
				idle_left = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed dates at the reset epoch
		for (int i = 0; i < DIR_ROWS; i++) begin
			if ($urandom_range(0, 99) < 25)
				pause_sender($urandom_range(1, 14));
			offer_date(date_rows[i].year, date_rows[i].month, date_rows[i].day,
				date_rows[i].typed, date_rows[i].status, date_rows[i].day_number);
		end
		drain_results();

		// epoch above max year: nothing passes
		write_epoch(14'h3FFF);
		run_phase(60, -1);
		drain_results();

		write_epoch(14'd9999);
		run_phase(60, -1);
		drain_results();

		// back to the usual epoch; hold off the result side to back up the pipe
		write_epoch(14'd2010);
		hold_start <= 1'b1;
		run_phase(500, -1);
		drain_results();

		write_epoch(14'($urandom_range(1, 2399)));
		run_phase(225, -1);
		drain_results();
		run_phase(225, -1);
		drain_results();

		write_epoch(14'd1);
		run_phase(400, -1);
		drain_results();

		// epoch zero, year zero leap; last stretch without idling
		write_epoch(14'd0);
		run_phase(350, 200);
		offer_date(14'd9999, 4'd12, 5'd31, 1'b0, ST_ACCEPTED, '0);
		offer_date(14'd0, 4'd2, 5'd29, 1'b1, ST_EARLIER, 22'd0);
		offer_date(14'd9999, 4'd12, 5'd31, 1'b0, ST_ACCEPTED, '0);
		drain_results();

		if (mismatches == 0)
			$display("PASS date_gap_tracker_core");
		else
			$display("FAIL date_gap_tracker_core");
		$finish;
	end

	initial begin : watchdog
		#1_000_000;
		$display("FAIL date_gap_tracker_core");
		$finish;
	end

endmodule

[filelist.f]
sv/dgt_pkg.sv
sv/date_gap_tracker_core.sv
tb/testbench.sv
